FILE: sv/object_name_case_folding_hash_unit_defines.svh
// assertion macros shared by the hash unit
`ifndef OBJECT_NAME_CASE_FOLDING_HASH_UNIT_DEFINES_SVH
`define OBJECT_NAME_CASE_FOLDING_HASH_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define OCFH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ocfh assertion failed");

// antecedent implies consequent in the next cycle
`define OCFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ocfh assertion failed");

`endif

FILE: sv/ocfh_pkg.sv
package ocfh_pkg;

    localparam logic [63:0] CASE_BIT_MASK = 64'h0020_0020_0020_0020;
    localparam logic [15:0] LOWER_FIRST   = 16'h0061;
    localparam logic [15:0] LOWER_LAST    = 16'h007a;
    localparam logic [15:0] UPPER_OFFSET  = 16'h0020;
    localparam int          GROUP_UNITS   = 4;
    localparam logic [1:0]  LAST_SLOT     = 2'(GROUP_UNITS - 1);

    // upper-case one unit and fold it into a 32-bit hash
    function automatic logic [31:0] fold_char(input logic [31:0] h, input logic [15:0] c);
        logic [15:0] u;
        u = (c >= LOWER_FIRST && c <= LOWER_LAST) ? c - UPPER_OFFSET : c;
        return h + {h[30:0], 1'b0} + {1'b0, h[31:1]} + {16'h0000, u};
    endfunction

endpackage

FILE: sv/object_name_case_folding_hash_unit.sv
// case-folding name hash unit
// input channel: in_valid / in_ready carry one utf-16 code unit per item
// (code_unit) and is_last, which marks the final unit of a name
// output channel: out_valid / out_ready carry one name_hash item per name,
// produced for the item that has is_last set; other items give no result
// throughput: one code unit per cycle, names back to back with no gap,
// while back-pressure does not hold a last unit; a name's last unit passes
// through the input register, fold-and-first-char stage, last-two-chars
// stage and output register; the 64-bit group add sits in the input stage
// back-pressure: when out_ready is low the output register holds its item,
// the stages behind it fill, and in_ready drops only once a last unit
// cannot move on; units that do not end a name keep flowing
// reset: rst_n clears the running value, the pending count and all valid
// flags; the first item after reset starts a new name
`include "object_name_case_folding_hash_unit_defines.svh"

module object_name_case_folding_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] name_hash
);
    import ocfh_pkg::*;

    // input register
    logic        s0_valid_reg;
    logic [15:0] s0_unit_reg;
    logic        s0_last_reg;

    // name state
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [15:0] pend_reg [3];

    // finishing stage
    logic        s1_valid_reg;
    logic [63:0] s1_acc_reg;
    logic [15:0] s1_unit_reg [3];
    logic [1:0]  s1_cnt_reg;

    // tail stage
    logic        s2_valid_reg;
    logic [31:0] s2_hash_reg;
    logic [15:0] s2_unit1_reg;
    logic [15:0] s2_unit2_reg;
    logic [1:0]  s2_cnt_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] hash_reg;

    logic        out_free;
    logic        s2_free;
    logic        s1_free;
    logic        s0_adv;
    logic [63:0] group;
    logic [63:0] acc_grown;
    logic [63:0] fin_acc;
    logic [1:0]  fin_cnt;
    logic [15:0] fin_unit [3];
    logic [31:0] s1_hash;
    logic [31:0] s2_hash;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_adv   = s0_valid_reg && (!s0_last_reg || s1_free);
    assign in_ready = !s0_valid_reg || s0_adv;

    assign out_valid = out_valid_reg;
    assign name_hash = hash_reg;

    // group completion and state update
    always_comb
    begin
        group     = {s0_unit_reg, pend_reg[2], pend_reg[1], pend_reg[0]} & ~CASE_BIT_MASK;
        acc_grown = acc_reg + {acc_reg[62:0], 1'b0} + {1'b0, acc_reg[63:1]} + group;
        for (int i = 0; i < 3; i++)
        begin
            fin_unit[i] = (cnt_reg == 2'(i)) ? s0_unit_reg : pend_reg[i];
        end
        if (cnt_reg == LAST_SLOT)
        begin
            fin_acc  = acc_grown;
            fin_cnt  = 2'd0;
            acc_next = acc_grown;
            cnt_next = 2'd0;
        end
        else
        begin
            fin_acc  = acc_reg;
            fin_cnt  = cnt_reg + 2'd1;
            acc_next = acc_reg;
            cnt_next = cnt_reg + 2'd1;
        end
        if (s0_last_reg)
        begin
            acc_next = '0;
            cnt_next = 2'd0;
        end
    end

    // fold to 32 bits, then the leftover units
    always_comb
    begin
        s1_hash = s1_acc_reg[31:0] + s1_acc_reg[63:32];
        if (s1_cnt_reg != 2'd0)
        begin
            s1_hash = fold_char(s1_hash, s1_unit_reg[0]);
        end
        s2_hash = s2_hash_reg;
        if (s2_cnt_reg == 2'd2 || s2_cnt_reg == 2'd3)
        begin
            s2_hash = fold_char(s2_hash, s2_unit1_reg);
        end
        if (s2_cnt_reg == 2'd3)
        begin
            s2_hash = fold_char(s2_hash, s2_unit2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= 2'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s0_adv)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_adv && s0_last_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s0_unit_reg <= code_unit;
            s0_last_reg <= is_last;
        end
        if (s0_adv)
        begin
            case (cnt_reg)
                2'd0:    pend_reg[0] <= s0_unit_reg;
                2'd1:    pend_reg[1] <= s0_unit_reg;
                2'd2:    pend_reg[2] <= s0_unit_reg;
                default: ;
            endcase
        end
        if (s1_free)
        begin
            s1_acc_reg  <= fin_acc;
            s1_unit_reg <= fin_unit;
            s1_cnt_reg  <= fin_cnt;
        end
        if (s2_free)
        begin
            s2_hash_reg  <= s1_hash;
            s2_unit1_reg <= s1_unit_reg[1];
            s2_unit2_reg <= s1_unit_reg[2];
            s2_cnt_reg   <= s1_cnt_reg;
        end
        if (out_free)
        begin
            hash_reg <= s2_hash;
        end
    end

    `OCFH_ASSERT_NEXT(a_name_end_clears, clk, rst_n,
        s0_adv && s0_last_reg, acc_reg == 64'd0 && cnt_reg == 2'd0)
    `OCFH_ASSERT_NEXT(a_group_wraps, clk, rst_n,
        s0_adv && cnt_reg == LAST_SLOT, cnt_reg == 2'd0)
    `OCFH_ASSERT_NEXT(a_last_reaches_s1, clk, rst_n,
        s0_adv && s0_last_reg, s1_valid_reg)
    `OCFH_ASSERT_NEXT(a_s1_holds, clk, rst_n,
        s1_valid_reg && !s2_free, s1_valid_reg && $stable(s1_acc_reg))
    `OCFH_ASSERT_SAME(a_plain_unit_flows, clk, rst_n,
        s0_valid_reg && !s0_last_reg, s0_adv && in_ready)

endmodule
